FILE: design/assert_macros.svh
// Assertion macros shared by the drive enable sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define CDES_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define CDES_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/cdes_pkg.sv
// Types and constants for the CiA402 drive enable sequencer.
package cdes_pkg;

    // Control words
    localparam logic [15:0] CW_OFF       = 16'h0000;
    localparam logic [15:0] CW_FAULT_RST = 16'h0080;
    localparam logic [15:0] CW_SHUTDOWN  = 16'h0006;
    localparam logic [15:0] CW_SWITCH_ON = 16'h0007;
    localparam logic [15:0] CW_ENABLE_OP = 16'h000F;

    // Status word masks and patterns
    localparam logic [15:0] SW_FAULT_BIT   = 16'h0008;
    localparam logic [15:0] SW_DIS_MASK    = 16'h004F;
    localparam logic [15:0] SW_DIS_PAT     = 16'h0040;
    localparam logic [15:0] SW_STATE_MASK  = 16'h006F;
    localparam logic [15:0] SW_READY_PAT   = 16'h0021;
    localparam logic [15:0] SW_SWITCH_PAT  = 16'h0023;
    localparam logic [15:0] SW_ENABLED_PAT = 16'h0027;
    localparam logic [15:0] SW_QSTOP_PAT   = 16'h0007;

    // Drive state codes
    typedef logic [2:0] t_ds;
    localparam t_ds DS_FAULT     = 3'd0;
    localparam t_ds DS_DISABLED  = 3'd1;
    localparam t_ds DS_READY     = 3'd2;
    localparam t_ds DS_SWITCHED  = 3'd3;
    localparam t_ds DS_ENABLED   = 3'd4;
    localparam t_ds DS_QUICKSTOP = 3'd5;
    localparam t_ds DS_OTHER     = 3'd6;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FAULT_LOW = 2'd0;
    localparam t_cfg_idx CFG_EN_WAIT   = 2'd1;
    localparam t_cfg_idx CFG_OP_MODE   = 2'd2;

    localparam logic [7:0]  FAULT_LOW_RST = 8'd10;
    localparam logic [15:0] EN_WAIT_RST   = 16'd100;
    localparam logic [7:0]  OP_MODE_RST   = 8'd9;

    typedef struct packed {
        logic [7:0]        fault_low_cycles;
        logic [15:0]       en_wait_len;
        logic signed [7:0] operation_mode;
    } t_cfg;

endpackage

FILE: design/cdes_decode.sv
// Status word to CiA402 drive state decode.
module cdes_decode (
    input  logic [15:0]  i_sw,
    output cdes_pkg::t_ds o_drive_state
);
    import cdes_pkg::*;

    logic [15:0] masked;

    assign masked = i_sw & SW_STATE_MASK;

    // First match wins: fault bit overrides everything
    always_comb begin
        if ((i_sw & SW_FAULT_BIT) != 16'h0000) begin
            o_drive_state = DS_FAULT;
        end else if ((i_sw & SW_DIS_MASK) == SW_DIS_PAT) begin
            o_drive_state = DS_DISABLED;
        end else if (masked == SW_READY_PAT) begin
            o_drive_state = DS_READY;
        end else if (masked == SW_SWITCH_PAT) begin
            o_drive_state = DS_SWITCHED;
        end else if (masked == SW_ENABLED_PAT) begin
            o_drive_state = DS_ENABLED;
        end else if (masked == SW_QSTOP_PAT) begin
            o_drive_state = DS_QUICKSTOP;
        end else begin
            o_drive_state = DS_OTHER;
        end
    end

endmodule

FILE: design/cdes_step.sv
// Control word selection, fault reset pacing and enable wait counter.
module cdes_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  cdes_pkg::t_cfg      i_cfg,
    input  cdes_pkg::t_ds       i_drive_state,
    input  logic                i_target_valid,
    input  logic signed [31:0]  i_target_velocity,
    output logic [15:0]         o_control_word,
    output logic signed [31:0]  o_velocity_command
);
    import cdes_pkg::*;

    logic [7:0]  r_fault_cnt, n_fault_cnt;
    logic [15:0] r_wait_cnt, n_wait_cnt;

    always_comb begin
        n_fault_cnt        = r_fault_cnt;
        n_wait_cnt         = r_wait_cnt;
        o_control_word     = CW_SHUTDOWN;
        o_velocity_command = 32'sd0;
        case (i_drive_state)
            DS_FAULT: begin
                if (r_fault_cnt < i_cfg.fault_low_cycles) begin
                    o_control_word = CW_OFF;
                    n_fault_cnt    = r_fault_cnt + 8'd1;
                end else begin
                    o_control_word = CW_FAULT_RST;
                    n_fault_cnt    = 8'd0;
                end
            end
            DS_READY: begin
                o_control_word = CW_SWITCH_ON;
            end
            DS_SWITCHED: begin
                o_control_word = CW_ENABLE_OP;
            end
            DS_ENABLED: begin
                o_control_word = CW_ENABLE_OP;
                // wait runs once after reset; never restarted
                if (r_wait_cnt < i_cfg.en_wait_len) begin
                    n_wait_cnt = r_wait_cnt + 16'd1;
                end else if (i_target_valid) begin
                    o_velocity_command = i_target_velocity;
                end
            end
            default: begin
                o_control_word = CW_SHUTDOWN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault_cnt <= 8'd0;
            r_wait_cnt  <= 16'd0;
        end else if (i_en) begin
            r_fault_cnt <= n_fault_cnt;
            r_wait_cnt  <= n_wait_cnt;
        end
    end

endmodule

FILE: design/cia402_drive_enable_sequencer.sv
// Top level of the CiA402 drive enable sequencer.
//
//  channel   dir  handshake               payload
//  s_*       in   i_s_tvalid/o_s_tready   tdata status/target, tuser target_valid
//  m_*       out  o_m_tvalid/i_m_tready   tdata control/velocity/mode/state
//  cfg_*     in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A request passes through the input register, then the result register.
// One request per clock sustained while results are taken; the decode and counters sit in one stage.
// Synchronous active-low reset clears valids, counters and config to defaults.
// A stalled result holds the result register; the input register still takes
// one more request, after which o_s_tready drops until the result is taken.
module cia402_drive_enable_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // [15:0] drive status, [47:16] target_velocity
    input  logic        i_s_tuser,   // [0] target_valid
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [15:0] control_word, [47:16] velocity_command, [55:48] mode_out,
    // [58:56] drive_state, [63:59] zero
    output logic [63:0] o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  cdes_pkg::t_cfg_idx i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import cdes_pkg::*;

    `include "assert_macros.svh"

    t_cfg r_cfg;

    logic               r_in_valid;
    logic [15:0]        r_drive_sw;
    logic               r_target_valid;
    logic signed [31:0] r_target_velocity;

    logic               r_out_valid;
    logic [15:0]        r_control_word;
    logic signed [31:0] r_velocity_command;
    logic signed [7:0]  r_mode_out;
    t_ds                r_drive_state;

    logic               move;
    logic               in_take;
    t_ds                drive_state;
    logic [15:0]        control_word;
    logic signed [31:0] velocity_command;

    // config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fault_low_cycles <= FAULT_LOW_RST;
            r_cfg.en_wait_len      <= EN_WAIT_RST;
            r_cfg.operation_mode   <= OP_MODE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FAULT_LOW: r_cfg.fault_low_cycles <= i_cfg_data[7:0];
                CFG_EN_WAIT:   r_cfg.en_wait_len      <= i_cfg_data;
                CFG_OP_MODE:   r_cfg.operation_mode   <= i_cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    // request moves into the result register when that is free or draining
    assign move       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || move;
    assign in_take    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_drive_sw        <= i_s_tdata[15:0];
            r_target_velocity <= i_s_tdata[47:16];
            r_target_valid    <= i_s_tuser;
        end
    end

    cdes_decode u_decode (
        .i_sw          (r_drive_sw),
        .o_drive_state (drive_state)
    );

    cdes_step u_step (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_en               (move),
        .i_cfg              (r_cfg),
        .i_drive_state      (drive_state),
        .i_target_valid     (r_target_valid),
        .i_target_velocity  (r_target_velocity),
        .o_control_word     (control_word),
        .o_velocity_command (velocity_command)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_control_word     <= control_word;
            r_velocity_command <= velocity_command;
            r_mode_out         <= r_cfg.operation_mode;
            r_drive_state      <= drive_state;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_drive_state, r_mode_out, r_velocity_command, r_control_word};

    `CDES_ASSERT_IMP(a_rst_pulse_in_fault, o_m_tvalid && (r_control_word == CW_FAULT_RST), r_drive_state == DS_FAULT, "fault reset word outside fault")
    `CDES_ASSERT_IMP(a_vel_only_enabled, o_m_tvalid && (r_velocity_command != 32'sd0), (r_drive_state == DS_ENABLED) && (r_control_word == CW_ENABLE_OP), "velocity passed while not enabled")
    `CDES_ASSERT_NXT(a_in_not_lost, r_in_valid && !move, r_in_valid && $stable(r_drive_sw), "held request dropped")
    `CDES_ASSERT_NXT(a_result_not_lost, r_out_valid && !i_m_tready, r_out_valid && $stable(r_control_word), "stalled result overwritten")

endmodule
